// ===== hw/rtl/caf_pkg.sv =====
// Package with operation codes and request/result types of the CPU ALU.
`default_nettype none

package caf_pkg;

	typedef enum logic [4:0] {
		FN_ADD   = 5'd0,
		FN_ADC   = 5'd1,
		FN_SUB   = 5'd2,
		FN_SBC   = 5'd3,
		FN_AND   = 5'd4,
		FN_XOR   = 5'd5,
		FN_OR    = 5'd6,
		FN_CP    = 5'd7,
		FN_INC   = 5'd8,
		FN_DEC   = 5'd9,
		FN_RLC   = 5'd10,
		FN_RRC   = 5'd11,
		FN_RL    = 5'd12,
		FN_RR    = 5'd13,
		FN_SLA   = 5'd14,
		FN_SRA   = 5'd15,
		FN_SWAP  = 5'd16,
		FN_SRL   = 5'd17,
		FN_BIT   = 5'd18,
		FN_RES   = 5'd19,
		FN_SET   = 5'd20,
		FN_DAA   = 5'd21,
		FN_CPL   = 5'd22,
		FN_SCF   = 5'd23,
		FN_CCF   = 5'd24,
		FN_ADD16 = 5'd25,
		FN_ADDSP = 5'd26,
		FN_RLCA  = 5'd27,
		FN_RRCA  = 5'd28,
		FN_RLA   = 5'd29,
		FN_RRA   = 5'd30
	} func_t;

	localparam logic [7:0] DAA_HI_ADJ = 8'h60;
	localparam logic [7:0] DAA_LO_ADJ = 8'h06;
	localparam logic [7:0] DAA_HI_LIM = 8'h99;
	localparam logic [3:0] DAA_LO_LIM = 4'd9;

	typedef struct packed {
		logic [4:0]  func;
		logic [15:0] operand_a;
		logic [15:0] operand_b;
		logic [2:0]  bit_index;
		logic        zero_in;
		logic        subtract_in;
		logic        half_in;
		logic        carry_in;
	} caf_req_t;

	typedef struct packed {
		logic [15:0] result;
		logic        write_result;
		logic        zero_out;
		logic        subtract_out;
		logic        half_out;
		logic        carry_out;
	} caf_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/caf_req_if.sv =====
// Valid/ready channel that carries ALU requests.
`default_nettype none

interface caf_req_if;
	import caf_pkg::*;

	logic     valid;
	logic     ready;
	caf_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/caf_rsp_if.sv =====
// Valid/ready channel that carries ALU results.
`default_nettype none

interface caf_rsp_if;
	import caf_pkg::*;

	logic     valid;
	logic     ready;
	caf_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cpu_alu_with_flags.sv =====
// Top level of the 8/16-bit CPU ALU with Z/N/H/C flag generation.
//
// The ALU takes one request per clock cycle while the result side does not stall.
// Each accepted request is captured in an input register, the arithmetic, logic,
// shift, bit and decimal-adjust network runs in a single pass, and the outcome
// lands in a result register. Both registers hold their contents while the
// result side stalls, and req.ready drops combinationally with rsp.ready only
// when both registers are full, so the pipe keeps streaming whenever the
// consumer takes results. The unused operation code passes operand_a through
// with the flags unchanged and no write-back.
`default_nettype none

module cpu_alu_with_flags (
	input  wire logic  clk,
	input  wire logic  arst_n,
	caf_req_if.sink    req,
	caf_rsp_if.source  rsp
);
	import caf_pkg::*;

	caf_req_t req_s1;
	logic     valid_s1;
	caf_rsp_t rsp_s2;
	logic     valid_s2;
	caf_rsp_t rsp_d;
	logic     adv_s2;
	logic     adv_s1;

	logic [7:0]  a;
	logic [7:0]  b;
	logic        cin;
	logic [8:0]  sum9;
	logic [4:0]  nib5;
	logic [16:0] sum17;
	logic [12:0] sum13;
	logic [7:0]  r8;
	logic [7:0]  daa_r;
	logic        daa_c;

	assign adv_s2    = !valid_s2 || rsp.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req.ready = adv_s1;
	assign rsp.valid = valid_s2;
	assign rsp.data  = rsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) begin
			req_s1 <= req.data;
		end
		if (adv_s2 && valid_s1) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign a = req_s1.operand_a[7:0];
	assign b = req_s1.operand_b[7:0];

	// Decimal adjust after an add or a subtract, driven by N, H and C.
	always_comb begin
		daa_r = a;
		daa_c = req_s1.carry_in;
		if (!req_s1.subtract_in) begin
			if (req_s1.carry_in || (a > DAA_HI_LIM)) begin
				daa_r = daa_r + DAA_HI_ADJ;
				daa_c = 1'b1;
			end
			if (req_s1.half_in || (daa_r[3:0] > DAA_LO_LIM)) begin
				daa_r = daa_r + DAA_LO_ADJ;
			end
		end else begin
			if (req_s1.carry_in) begin
				daa_r = daa_r - DAA_HI_ADJ;
			end
			if (req_s1.half_in) begin
				daa_r = daa_r - DAA_LO_ADJ;
			end
		end
	end

	always_comb begin
		rsp_d.result       = req_s1.operand_a;
		rsp_d.write_result = 1'b1;
		rsp_d.zero_out     = req_s1.zero_in;
		rsp_d.subtract_out = req_s1.subtract_in;
		rsp_d.half_out     = req_s1.half_in;
		rsp_d.carry_out    = req_s1.carry_in;
		cin   = 1'b0;
		sum9  = '0;
		nib5  = '0;
		sum17 = '0;
		sum13 = '0;
		r8    = a;

		unique case (req_s1.func)
			FN_ADD, FN_ADC: begin
				cin  = (req_s1.func == FN_ADC) && req_s1.carry_in;
				sum9 = {1'b0, a} + {1'b0, b} + {8'd0, cin};
				nib5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
				r8   = sum9[7:0];
				rsp_d.subtract_out = 1'b0;
				rsp_d.half_out     = nib5[4];
				rsp_d.carry_out    = sum9[8];
			end
			FN_SUB, FN_SBC, FN_CP: begin
				// The top bit of each widened difference is the borrow.
				cin  = (req_s1.func == FN_SBC) && req_s1.carry_in;
				sum9 = {1'b0, a} - {1'b0, b} - {8'd0, cin};
				nib5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
				r8   = sum9[7:0];
				rsp_d.write_result = (req_s1.func != FN_CP);
				rsp_d.subtract_out = 1'b1;
				rsp_d.half_out     = nib5[4];
				rsp_d.carry_out    = sum9[8];
			end
			FN_AND: begin
				r8 = a & b;
				rsp_d.subtract_out = 1'b0;
				rsp_d.half_out     = 1'b1;
				rsp_d.carry_out    = 1'b0;
			end
			FN_XOR, FN_OR: begin
				r8 = (req_s1.func == FN_XOR) ? (a ^ b) : (a | b);
				rsp_d.subtract_out = 1'b0;
				rsp_d.half_out     = 1'b0;
				rsp_d.carry_out    = 1'b0;
			end
			FN_INC: begin
				r8 = a + 8'd1;
				rsp_d.subtract_out = 1'b0;
				rsp_d.half_out     = (r8[3:0] == 4'h0);
			end
			FN_DEC: begin
				r8 = a - 8'd1;
				rsp_d.subtract_out = 1'b1;
				rsp_d.half_out     = (r8[3:0] == 4'hF);
			end
			FN_RLC, FN_RLCA, FN_RL, FN_RLA, FN_SLA: begin
				unique case (req_s1.func)
					FN_RLC, FN_RLCA: r8 = {a[6:0], a[7]};
					FN_RL, FN_RLA:   r8 = {a[6:0], req_s1.carry_in};
					default:         r8 = {a[6:0], 1'b0};
				endcase
				rsp_d.subtract_out = 1'b0;
				rsp_d.half_out     = 1'b0;
				rsp_d.carry_out    = a[7];
			end
			FN_RRC, FN_RRCA, FN_RR, FN_RRA, FN_SRA, FN_SRL: begin
				unique case (req_s1.func)
					FN_RRC, FN_RRCA: r8 = {a[0], a[7:1]};
					FN_RR, FN_RRA:   r8 = {req_s1.carry_in, a[7:1]};
					FN_SRA:          r8 = {a[7], a[7:1]};
					default:         r8 = {1'b0, a[7:1]};
				endcase
				rsp_d.subtract_out = 1'b0;
				rsp_d.half_out     = 1'b0;
				rsp_d.carry_out    = a[0];
			end
			FN_SWAP: begin
				r8 = {a[3:0], a[7:4]};
				rsp_d.subtract_out = 1'b0;
				rsp_d.half_out     = 1'b0;
				rsp_d.carry_out    = 1'b0;
			end
			FN_BIT: begin
				rsp_d.write_result = 1'b0;
				rsp_d.subtract_out = 1'b0;
				rsp_d.half_out     = 1'b1;
			end
			FN_RES: r8 = a & ~(8'd1 << req_s1.bit_index);
			FN_SET: r8 = a | (8'd1 << req_s1.bit_index);
			FN_DAA: begin
				r8 = daa_r;
				rsp_d.half_out  = 1'b0;
				rsp_d.carry_out = daa_c;
			end
			FN_CPL: begin
				r8 = ~a;
				rsp_d.subtract_out = 1'b1;
				rsp_d.half_out     = 1'b1;
			end
			FN_SCF, FN_CCF: begin
				rsp_d.subtract_out = 1'b0;
				rsp_d.half_out     = 1'b0;
				rsp_d.carry_out    = (req_s1.func == FN_SCF) ? 1'b1 : !req_s1.carry_in;
			end
			FN_ADD16: begin
				sum17 = {1'b0, req_s1.operand_a} + {1'b0, req_s1.operand_b};
				sum13 = {1'b0, req_s1.operand_a[11:0]} + {1'b0, req_s1.operand_b[11:0]};
				rsp_d.subtract_out = 1'b0;
				rsp_d.half_out     = sum13[12];
				rsp_d.carry_out    = sum17[16];
			end
			FN_ADDSP: begin
				// H and C come from the unsigned add of the low bytes.
				sum17 = {1'b0, req_s1.operand_a} + {1'b0, {8{b[7]}}, b};
				sum9  = {1'b0, a} + {1'b0, b};
				nib5  = {1'b0, a[3:0]} + {1'b0, b[3:0]};
				rsp_d.zero_out     = 1'b0;
				rsp_d.subtract_out = 1'b0;
				rsp_d.half_out     = nib5[4];
				rsp_d.carry_out    = sum9[8];
			end
			default: rsp_d.write_result = 1'b0;
		endcase

		unique case (req_s1.func)
			FN_ADD16, FN_ADDSP: rsp_d.result = sum17[15:0];
			FN_RES, FN_SET, FN_CPL, FN_SCF, FN_CCF, FN_BIT: rsp_d.result = {8'd0, r8};
			FN_ADD, FN_ADC, FN_SUB, FN_SBC, FN_CP, FN_AND, FN_XOR, FN_OR, FN_INC,
			FN_DEC, FN_RLC, FN_RRC, FN_RL, FN_RR, FN_SLA, FN_SRA, FN_SWAP, FN_SRL,
			FN_DAA: begin
				rsp_d.result   = {8'd0, r8};
				rsp_d.zero_out = (r8 == 8'd0);
			end
			FN_RLCA, FN_RRCA, FN_RLA, FN_RRA: begin
				rsp_d.result   = {8'd0, r8};
				rsp_d.zero_out = 1'b0;
			end
			default: rsp_d.result = req_s1.operand_a;
		endcase

		if (req_s1.func == FN_BIT) begin
			rsp_d.zero_out = !a[req_s1.bit_index];
		end
	end

endmodule

`default_nettype wire
